// ===== sv/assist_control_breath_sequencer_core_macros.svh =====
// Assertion macros for the breath sequencer checker.
// Assumes clk_i and rst_ni are visible in the scope that uses them.
`ifndef ASSIST_CONTROL_BREATH_SEQUENCER_CORE_MACROS_SVH
`define ASSIST_CONTROL_BREATH_SEQUENCER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ACBS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ACBS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/acbs_pkg.sv =====
// Shared types and constants for the assist-control breath sequencer.
// No dependencies; used by the core, the margin check and the checker.
`default_nettype none

package acbs_pkg;

  localparam int unsigned PressW  = 16;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned MsCfgW  = 16;
  localparam int unsigned PresCfgW = 15;
  localparam int unsigned MarginW = 10;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [3:0] {
    PH_START   = 4'd0,
    PH_WAIT    = 4'd1,
    PH_INHCMD  = 4'd2,
    PH_INHALE  = 4'd3,
    PH_ABORT   = 4'd4,
    PH_PLATEAU = 4'd5,
    PH_EXHCMD  = 4'd6,
    PH_EXHALE  = 4'd7,
    PH_RESET   = 4'd8
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TRIG_TIMEOUT = 3'd0,
    CFG_TRIG_DROP    = 3'd1,
    CFG_INHALE       = 3'd2,
    CFG_PLATEAU      = 3'd3,
    CFG_RETURN       = 3'd4,
    CFG_PIP_LIMIT    = 3'd5,
    CFG_MARGIN       = 3'd6
  } cfg_idx_e;

  localparam logic [MsCfgW-1:0]   TrigTimeoutRst = 16'd5000;
  localparam logic [PresCfgW-1:0] TrigDropRst    = 15'd200;
  localparam logic [MsCfgW-1:0]   InhaleRst      = 16'd1000;
  localparam logic [MsCfgW-1:0]   PlateauRst     = 16'd300;
  localparam logic [MsCfgW-1:0]   ReturnRst      = 16'd1000;
  localparam logic [PresCfgW-1:0] PipLimitRst    = 15'd4000;
  localparam logic [MarginW-1:0]  MarginRst      = 10'd256;

endpackage

`default_nettype wire

// ===== sv/acbs_margin_chk.sv =====
// High-PIP check: pressure times Q2.8 margin, floored, saturated, compared.
// Depends on acbs_pkg for widths.
`default_nettype none

module acbs_margin_chk (
  input  logic signed [acbs_pkg::PressW-1:0]   pressure_i,
  input  logic        [acbs_pkg::MarginW-1:0]  margin_i,
  input  logic        [acbs_pkg::PresCfgW-1:0] limit_i,
  output logic                                 over_o
);

  logic signed [25:0] prod;
  logic signed [17:0] scaled;
  logic signed [15:0] sat;

  // Dropping the low eight bits of a two's complement value floors it.
  assign prod   = pressure_i * $signed({1'b0, margin_i});
  assign scaled = prod[25:8];

  always_comb begin
    if (scaled > 18'sd32767) begin
      sat = 16'sh7FFF;
    end else if (scaled < -18'sd32768) begin
      sat = 16'sh8000;
    end else begin
      sat = scaled[15:0];
    end
  end

  assign over_o = $signed({{2{sat[15]}}, sat}) > $signed({3'b000, limit_i});

endmodule

`default_nettype wire

// ===== sv/assist_control_breath_sequencer_core.sv =====
// Top level of the assist-control breath sequencer.
// Depends on acbs_pkg and acbs_margin_chk.
`default_nettype none

// One input beat is one step of the breath cycle (start, trigger wait,
// inhale command, inhale, abort, plateau, exhale command, exhale, reset)
// and yields exactly one result beat. A beat is taken into an input
// register; from there the phase logic and the margin multiply work
// on it and load the result register and the breath state together. The
// block takes one beat per cycle while out_stall_i is low: the input
// register refills in the same cycle in which its beat moves into the
// result register, and the result register reloads in the cycle its beat
// is taken. A beat passes the input register and then the result
// register before it leaves. in_stall_o rises only while both
// registers are full and out_stall_i is high. Configuration writes land at
// once on a rising edge with cfg_we_i high; write them only while no beat
// is in flight. Indexes past the last register are dropped.
module assist_control_breath_sequencer_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration write port
  input  logic                                 cfg_we_i,
  input  logic        [acbs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic        [acbs_pkg::CfgDataW-1:0] cfg_wdata_i,
  // Input channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic        [acbs_pkg::TimeW-1:0]    now_ms_i,
  input  logic signed [acbs_pkg::PressW-1:0]   pressure_i,
  // Result channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic        [3:0]                    phase_o,
  output logic                                 motor_stop_o,
  output logic                                 pip_abort_o,
  output logic                                 breath_done_o,
  output logic signed [acbs_pkg::PressW-1:0]   last_peak_o,
  output logic signed [acbs_pkg::PressW-1:0]   last_plateau_o,
  output logic signed [acbs_pkg::PressW-1:0]   last_peep_o
);

  // Configuration registers
  logic [acbs_pkg::MsCfgW-1:0]   trig_timeout_q;
  logic [acbs_pkg::PresCfgW-1:0] trig_drop_q;
  logic [acbs_pkg::MsCfgW-1:0]   inhale_ms_q;
  logic [acbs_pkg::MsCfgW-1:0]   plateau_ms_q;
  logic [acbs_pkg::MsCfgW-1:0]   return_ms_q;
  logic [acbs_pkg::PresCfgW-1:0] pip_limit_q;
  logic [acbs_pkg::MarginW-1:0]  margin_q;

  // Input register
  logic                                in_vld_q;
  logic [acbs_pkg::TimeW-1:0]          now_q;
  logic signed [acbs_pkg::PressW-1:0]  pres_q;

  // Breath state
  acbs_pkg::phase_e                    phase_q, phase_d;
  logic [acbs_pkg::TimeW-1:0]          timer_start_q, timer_start_d;
  logic signed [acbs_pkg::PressW-1:0]  run_peak_q, run_peak_d;
  logic signed [acbs_pkg::PressW-1:0]  peak_hold_q, peak_hold_d;
  logic signed [acbs_pkg::PressW-1:0]  plat_hold_q, plat_hold_d;
  logic signed [acbs_pkg::PressW-1:0]  peep_hold_q, peep_hold_d;

  // Result register (pulses; the hold values and phase are read from state)
  logic out_vld_q;
  logic stop_q, stop_d;
  logic abort_q, abort_d;
  logic done_q, done_d;

  logic                               fire;
  logic                               in_acc;
  logic [acbs_pkg::TimeW-1:0]         elapsed;
  logic signed [acbs_pkg::PressW:0]   trig_thr;
  logic signed [acbs_pkg::PressW-1:0] peak_upd;
  logic                               pip_over;
  logic                               timeout_wait;
  logic                               timeout_inh;
  logic                               timeout_plat;
  logic                               timeout_ret;
  logic                               trig_drop_hit;

  // Handshake: advance the input beat whenever the result slot is free or
  // being drained this cycle.
  assign fire       = in_vld_q & (~out_vld_q | ~out_stall_i);
  assign in_stall_o = in_vld_q & ~fire;
  assign in_acc     = in_valid_i & ~in_stall_o;

  // Step datapath
  assign elapsed       = now_q - timer_start_q;
  assign timeout_wait  = elapsed > {16'd0, trig_timeout_q};
  assign timeout_inh   = elapsed > {16'd0, inhale_ms_q};
  assign timeout_plat  = elapsed > {16'd0, plateau_ms_q};
  assign timeout_ret   = elapsed > {16'd0, return_ms_q};
  assign trig_thr      = $signed({peep_hold_q[15], peep_hold_q})
                         - $signed({2'b00, trig_drop_q});
  assign trig_drop_hit = $signed({pres_q[15], pres_q}) < trig_thr;
  assign peak_upd      = (pres_q > run_peak_q) ? pres_q : run_peak_q;

  acbs_margin_chk u_margin (
    .pressure_i (pres_q),
    .margin_i   (margin_q),
    .limit_i    (pip_limit_q),
    .over_o     (pip_over)
  );

  // Phase logic
  always_comb begin
    phase_d       = phase_q;
    timer_start_d = timer_start_q;
    run_peak_d    = run_peak_q;
    peak_hold_d   = peak_hold_q;
    plat_hold_d   = plat_hold_q;
    peep_hold_d   = peep_hold_q;
    stop_d        = 1'b0;
    abort_d       = 1'b0;
    done_d        = 1'b0;
    unique case (phase_q)
      acbs_pkg::PH_START: begin
        timer_start_d = now_q;
        run_peak_d    = '0;
        phase_d       = acbs_pkg::PH_WAIT;
      end
      acbs_pkg::PH_WAIT: begin
        // Forced breath on timeout, patient breath on a pressure drop.
        if (timeout_wait || trig_drop_hit) begin
          phase_d = acbs_pkg::PH_INHCMD;
        end
      end
      acbs_pkg::PH_INHCMD: begin
        timer_start_d = now_q;
        phase_d       = acbs_pkg::PH_INHALE;
      end
      acbs_pkg::PH_INHALE: begin
        run_peak_d = peak_upd;
        // Abort takes priority over the normal end of inhale.
        if (pip_over) begin
          stop_d        = 1'b1;
          abort_d       = 1'b1;
          peak_hold_d   = peak_upd;
          timer_start_d = now_q;
          phase_d       = acbs_pkg::PH_ABORT;
        end else if (timeout_inh) begin
          peak_hold_d   = peak_upd;
          timer_start_d = now_q;
          phase_d       = acbs_pkg::PH_PLATEAU;
        end
      end
      acbs_pkg::PH_ABORT: begin
        phase_d = acbs_pkg::PH_EXHALE;
      end
      acbs_pkg::PH_PLATEAU: begin
        if (timeout_plat) begin
          timer_start_d = now_q;
          phase_d       = acbs_pkg::PH_EXHCMD;
        end
      end
      acbs_pkg::PH_EXHCMD: begin
        plat_hold_d = pres_q;
        phase_d     = acbs_pkg::PH_EXHALE;
      end
      acbs_pkg::PH_EXHALE: begin
        if (timeout_ret) begin
          phase_d = acbs_pkg::PH_RESET;
        end
      end
      acbs_pkg::PH_RESET: begin
        peep_hold_d = pres_q;
        done_d      = 1'b1;
        phase_d     = acbs_pkg::PH_START;
      end
      default: begin
        // Unused phase code: restart the cycle, touch nothing else.
        phase_d = acbs_pkg::PH_START;
      end
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_timeout_q <= acbs_pkg::TrigTimeoutRst;
      trig_drop_q    <= acbs_pkg::TrigDropRst;
      inhale_ms_q    <= acbs_pkg::InhaleRst;
      plateau_ms_q   <= acbs_pkg::PlateauRst;
      return_ms_q    <= acbs_pkg::ReturnRst;
      pip_limit_q    <= acbs_pkg::PipLimitRst;
      margin_q       <= acbs_pkg::MarginRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        acbs_pkg::CFG_TRIG_TIMEOUT: trig_timeout_q <= cfg_wdata_i;
        acbs_pkg::CFG_TRIG_DROP:    trig_drop_q    <= cfg_wdata_i[acbs_pkg::PresCfgW-1:0];
        acbs_pkg::CFG_INHALE:       inhale_ms_q    <= cfg_wdata_i;
        acbs_pkg::CFG_PLATEAU:      plateau_ms_q   <= cfg_wdata_i;
        acbs_pkg::CFG_RETURN:       return_ms_q    <= cfg_wdata_i;
        acbs_pkg::CFG_PIP_LIMIT:    pip_limit_q    <= cfg_wdata_i[acbs_pkg::PresCfgW-1:0];
        acbs_pkg::CFG_MARGIN:       margin_q       <= cfg_wdata_i[acbs_pkg::MarginW-1:0];
        default: begin
          // Drop writes past the last register.
        end
      endcase
    end
  end

  // Input register: load on accept, hold while stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_acc) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      now_q  <= now_ms_i;
      pres_q <= pressure_i;
    end
  end

  // Breath state and result register advance together, so the hold values
  // always match the beat sitting in the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= acbs_pkg::PH_START;
      timer_start_q <= '0;
      run_peak_q    <= '0;
      peak_hold_q   <= '0;
      plat_hold_q   <= '0;
      peep_hold_q   <= '0;
      out_vld_q     <= 1'b0;
    end else begin
      if (fire) begin
        phase_q       <= phase_d;
        timer_start_q <= timer_start_d;
        run_peak_q    <= run_peak_d;
        peak_hold_q   <= peak_hold_d;
        plat_hold_q   <= plat_hold_d;
        peep_hold_q   <= peep_hold_d;
        out_vld_q     <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q     <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      stop_q  <= stop_d;
      abort_q <= abort_d;
      done_q  <= done_d;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign phase_o        = phase_q;
  assign motor_stop_o   = stop_q;
  assign pip_abort_o    = abort_q;
  assign breath_done_o  = done_q;
  assign last_peak_o    = peak_hold_q;
  assign last_plateau_o = plat_hold_q;
  assign last_peep_o    = peep_hold_q;

endmodule

`default_nettype wire

// ===== sv/acbs_checker.sv =====
// Port-level checker for the breath sequencer core, bound to the top level.
// Depends on acbs_pkg and assist_control_breath_sequencer_core_macros.svh.
`default_nettype none
`include "assist_control_breath_sequencer_core_macros.svh"

module acbs_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_stall_o,
  input logic                                 out_valid_o,
  input logic                                 out_stall_i,
  input logic        [3:0]                    phase_o,
  input logic                                 motor_stop_o,
  input logic                                 pip_abort_o,
  input logic                                 breath_done_o,
  input logic signed [acbs_pkg::PressW-1:0]   last_peak_o,
  input logic signed [acbs_pkg::PressW-1:0]   last_plateau_o,
  input logic signed [acbs_pkg::PressW-1:0]   last_peep_o
);

  `ACBS_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(phase_o) && $stable(motor_stop_o) && $stable(pip_abort_o) &&
    $stable(breath_done_o) && $stable(last_peak_o) && $stable(last_plateau_o) &&
    $stable(last_peep_o),
    "result beat changed while stalled")

  `ACBS_ASSERT_IMP(a_in_stall_cause, in_stall_o, out_valid_o && out_stall_i,
    "input stalled while result slot free")

  `ACBS_ASSERT_IMP(a_abort_pair, out_valid_o,
    (pip_abort_o == motor_stop_o) && (!pip_abort_o || phase_o == acbs_pkg::PH_ABORT),
    "abort pulse without motor stop or abort phase")

  `ACBS_ASSERT_IMP(a_done_phase, out_valid_o && breath_done_o,
    phase_o == acbs_pkg::PH_START,
    "breath done outside restart")

endmodule

bind assist_control_breath_sequencer_core acbs_checker u_acbs_checker (.*);

`default_nettype wire

// ===== sim/acbs_tb_pkg.sv =====
// Scoreboard for the breath sequencer testbench: predicts each result beat and checks it.
// Depends on acbs_pkg for widths, phase codes, register indexes and reset values.
package acbs_tb_pkg;
  import acbs_pkg::*;

  typedef struct packed {
    logic [3:0]               phase;
    logic                     motor_stop;
    logic                     pip_abort;
    logic                     breath_done;
    logic signed [PressW-1:0] last_peak;
    logic signed [PressW-1:0] last_plateau;
    logic signed [PressW-1:0] last_peep;
  } breath_beat_t;

  class breath_scoreboard;
    logic [MsCfgW-1:0]        trig_timeout;
    logic [PresCfgW-1:0]      trig_drop;
    logic [MsCfgW-1:0]        inhale_len;
    logic [MsCfgW-1:0]        plateau_len;
    logic [MsCfgW-1:0]        return_len;
    logic [PresCfgW-1:0]      pip_limit;
    logic [MarginW-1:0]       margin;

    phase_e                   phase;
    logic [TimeW-1:0]         t_start;
    logic signed [PressW-1:0] run_peak;
    logic signed [PressW-1:0] peak_hold;
    logic signed [PressW-1:0] plat_hold;
    logic signed [PressW-1:0] peep_hold;

    breath_beat_t             due_beats[$];
    int unsigned              mismatches;

    function new();
      trig_timeout = TrigTimeoutRst;
      trig_drop    = TrigDropRst;
      inhale_len   = InhaleRst;
      plateau_len  = PlateauRst;
      return_len   = ReturnRst;
      pip_limit    = PipLimitRst;
      margin       = MarginRst;
      phase        = PH_START;
      t_start      = '0;
      run_peak     = '0;
      peak_hold    = '0;
      plat_hold    = '0;
      peep_hold    = '0;
      mismatches   = 0;
    endfunction

    // Mask to the register width; drop unknown indexes.
    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_TRIG_TIMEOUT: trig_timeout = data[MsCfgW-1:0];
        CFG_TRIG_DROP:    trig_drop    = data[PresCfgW-1:0];
        CFG_INHALE:       inhale_len   = data[MsCfgW-1:0];
        CFG_PLATEAU:      plateau_len  = data[MsCfgW-1:0];
        CFG_RETURN:       return_len   = data[MsCfgW-1:0];
        CFG_PIP_LIMIT:    pip_limit    = data[PresCfgW-1:0];
        CFG_MARGIN:       margin       = data[MarginW-1:0];
        default: ;
      endcase
    endfunction

    // Q2.8 margin product, floored, saturated to the pressure range.
    function int scaled_pressure(logic signed [PressW-1:0] p);
      int prod;
      prod = int'(p) * int'(margin);
      prod = prod >>> 8;
      if (prod > 32767) prod = 32767;
      else if (prod < -32768) prod = -32768;
      return prod;
    endfunction

    function void note_step(logic [TimeW-1:0] now, logic signed [PressW-1:0] p);
      logic [TimeW-1:0] elapsed;
      breath_beat_t     beat;
      elapsed          = now - t_start;
      beat.motor_stop  = 1'b0;
      beat.pip_abort   = 1'b0;
      beat.breath_done = 1'b0;
      case (phase)
        PH_START: begin
          t_start  = now;
          run_peak = '0;
          phase    = PH_WAIT;
        end
        PH_WAIT: begin
          if (elapsed > trig_timeout) phase = PH_INHCMD;
          else if (int'(p) < int'(peep_hold) - int'(trig_drop)) phase = PH_INHCMD;
        end
        PH_INHCMD: begin
          t_start = now;
          phase   = PH_INHALE;
        end
        PH_INHALE: begin
          if (p > run_peak) run_peak = p;
          // abort wins over the inhale timeout
          if (scaled_pressure(p) > int'(pip_limit)) begin
            beat.motor_stop = 1'b1;
            beat.pip_abort  = 1'b1;
            peak_hold       = run_peak;
            t_start         = now;
            phase           = PH_ABORT;
          end else if (elapsed > inhale_len) begin
            peak_hold = run_peak;
            t_start   = now;
            phase     = PH_PLATEAU;
          end
        end
        PH_ABORT: phase = PH_EXHALE;
        PH_PLATEAU: begin
          if (elapsed > plateau_len) begin
            t_start = now;
            phase   = PH_EXHCMD;
          end
        end
        PH_EXHCMD: begin
          plat_hold = p;
          phase     = PH_EXHALE;
        end
        PH_EXHALE: begin
          if (elapsed > return_len) phase = PH_RESET;
        end
        PH_RESET: begin
          peep_hold        = p;
          beat.breath_done = 1'b1;
          phase            = PH_START;
        end
        default: phase = PH_START;
      endcase
      beat.phase        = phase;
      beat.last_peak    = peak_hold;
      beat.last_plateau = plat_hold;
      beat.last_peep    = peep_hold;
      due_beats.push_back(beat);
    endfunction

    function void check_result(breath_beat_t got);
      breath_beat_t want;
      if (due_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: phase %0d stop %0b abort %0b done %0b",
                   got.phase, got.motor_stop, got.pip_abort, got.breath_done);
        return;
      end
      want = due_beats.pop_front();
      if (got.phase !== want.phase || got.motor_stop !== want.motor_stop ||
          got.pip_abort !== want.pip_abort || got.breath_done !== want.breath_done ||
          got.last_peak !== want.last_peak || got.last_plateau !== want.last_plateau ||
          got.last_peep !== want.last_peep) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display({"result mismatch, expected: phase %0d stop %0b abort %0b done %0b",
                    " peak %0d plat %0d peep %0d"},
                   want.phase, want.motor_stop, want.pip_abort, want.breath_done,
                   $signed(want.last_peak), $signed(want.last_plateau),
                   $signed(want.last_peep));
          $display({"                 actual:   phase %0d stop %0b abort %0b done %0b",
                    " peak %0d plat %0d peep %0d"},
                   got.phase, got.motor_stop, got.pip_abort, got.breath_done,
                   $signed(got.last_peak), $signed(got.last_plateau),
                   $signed(got.last_peep));
        end
      end
    endfunction

    function int unsigned pending();
      return due_beats.size();
    endfunction
  endclass

endpackage

// ===== sim/tb_assist_control_breath_sequencer_core.sv =====
// Testbench top for assist_control_breath_sequencer_core: directed and random breath steps,
// each result beat checked against the scoreboard prediction. Depends on acbs_pkg, acbs_tb_pkg.
module tb_assist_control_breath_sequencer_core;
  timeunit 1ns;
  timeprecision 1ps;

  import acbs_pkg::*;
  import acbs_tb_pkg::*;

  localparam int unsigned        IdlePct      = 38;
  localparam int unsigned        QuietLimit   = 1000;
  localparam int unsigned        SettleCycles = 4;
  localparam logic [CfgIdxW-1:0] CfgIdxUnused = 3'd7;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]       cfg_idx_i   = '0;
  logic [CfgDataW-1:0]      cfg_wdata_i = '0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_stall_o;
  logic [TimeW-1:0]         now_ms_i    = '0;
  logic signed [PressW-1:0] pressure_i  = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic [3:0]               phase_o;
  logic                     motor_stop_o;
  logic                     pip_abort_o;
  logic                     breath_done_o;
  logic signed [PressW-1:0] last_peak_o;
  logic signed [PressW-1:0] last_plateau_o;
  logic signed [PressW-1:0] last_peep_o;

  // Random idling on both channels; cleared for one long quiet stretch.
  logic             idle_on  = 1'b1;
  // Running timestamp of the random stimulus.
  logic [TimeW-1:0] now_cur  = '0;
  int unsigned      idle_run = 0;

  breath_scoreboard breath_sb = new();

  assist_control_breath_sequencer_core i_dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Result side: stall at random while idling is on.
  always @(posedge clk_i) begin
    out_stall_i <= idle_on && ($urandom_range(99) < IdlePct);
  end

  // Monitor: check the result beat before noting the input beat of the same edge,
  // so a spurious result can never pair with a step that was just taken.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        breath_sb.check_result('{phase_o, motor_stop_o, pip_abort_o, breath_done_o,
                                 last_peak_o, last_plateau_o, last_peep_o});
      if (in_valid_i && !in_stall_o)
        breath_sb.note_step(now_ms_i, pressure_i);
      // Watchdog: count cycles in which no beat moves on either channel.
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)) begin
        idle_run <= 0;
      end else if (idle_run + 1 >= QuietLimit) begin
        $display("tb_assist_control_breath_sequencer_core: FAIL");
        $finish;
      end else begin
        idle_run <= idle_run + 1;
      end
    end
  end

  // Offer one step, idling first at random; return at the edge that takes it.
  task automatic send_step(input logic [TimeW-1:0] now, input logic signed [PressW-1:0] p);
    while (idle_on && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    now_ms_i   <= now;
    pressure_i <= p;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Hold the sender until every predicted beat has come back, then let the block settle.
  // Poll at the falling edge so the monitor has finished with the rising one.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (breath_sb.pending() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // One configuration write; the caller drops the write enable after the last one.
  task automatic cfg_beat(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    breath_sb.write_reg(idx, data);
  endtask

  task automatic load_settings(input logic [CfgDataW-1:0] trig_to, trig_dr, inh, plat, ret,
                               pip, marg);
    cfg_beat(CFG_TRIG_TIMEOUT, trig_to);
    cfg_beat(CFG_TRIG_DROP, trig_dr);
    cfg_beat(CFG_INHALE, inh);
    cfg_beat(CFG_PLATEAU, plat);
    cfg_beat(CFG_RETURN, ret);
    cfg_beat(CFG_PIP_LIMIT, pip);
    cfg_beat(CFG_MARGIN, marg);
    // the block must drop a write past the last register
    cfg_beat(CfgIdxUnused, CfgDataW'($urandom));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly forward time in steps around the timer span, pressures near PEEP with
  // inhale-like and high excursions; a few backward or wild jumps and full-range samples.
  task automatic random_breaths(input int unsigned count, input int unsigned span);
    int unsigned              n;
    int unsigned              pick;
    logic signed [PressW-1:0] p;
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 55) now_cur = now_cur + $urandom_range(span / 4 + 1);
      else if (pick < 85) now_cur = now_cur + $urandom_range(span + 2);
      else if (pick < 95) now_cur = now_cur + $urandom_range(70000);
      else now_cur = $urandom;
      pick = $urandom_range(99);
      if (pick < 45) p = PressW'(int'($urandom_range(1600)) - 1000);
      else if (pick < 75) p = PressW'($urandom_range(6000));
      else if (pick < 90) p = PressW'($urandom_range(32767));
      else p = PressW'($urandom);
      send_step(now_cur, p);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed pass on the reset settings: every phase, strict timer compares,
    // the trigger drop edge, timestamp wrap, pressure extremes, abort with timeout.
    send_step(32'd100, 16'sd0);              // start, arm the trigger timer
    send_step(32'd5100, 16'sd0);             // elapsed equals timeout: hold
    send_step(32'd5100, -16'sd200);          // pressure equals PEEP minus drop: hold
    send_step(32'd5101, -16'sd201);          // timeout one past the limit
    send_step(32'd5200, 16'sd0);             // inhale command
    send_step(32'd5300, 16'sd4000);          // scaled pressure equals limit: no abort
    send_step(32'd5400, -16'sd32768);        // lowest pressure, peak unchanged
    send_step(32'd6200, 16'sd1000);          // elapsed equals inhale time: hold
    send_step(32'd6201, 16'sd1500);          // into plateau, latch peak
    send_step(32'd6501, 16'sd0);
    send_step(32'd6502, 16'sd0);             // exhale command
    send_step(32'd6600, 16'sd2500);          // latch plateau pressure
    send_step(32'd7503, 16'sd0);             // exhale done
    send_step(32'd7600, 16'sd500);           // reset step, latch PEEP
    send_step(32'hFFFF_FF00, 16'sd0);        // start just before the wrap
    send_step(32'h0000_0010, 16'sd299);      // patient trigger across the wrap
    send_step(32'h0000_0020, 16'sd0);
    send_step(32'h0000_0021, 16'sd4001);     // abort on high pressure
    send_step(32'h0000_0022, 16'sd0);        // abort step into exhale
    send_step(32'hFFFF_FFFF, 16'sd32767);    // highest timestamp and pressure
    send_step(32'h0000_0000, -16'sd32768);   // PEEP at the floor
    send_step(32'd1, 16'sd0);
    send_step(32'd6000, 16'sd0);             // trigger by timeout only
    send_step(32'd6001, 16'sd0);
    send_step(32'd8000, 16'sd32767);         // abort and inhale timeout together
    wait_for_results();

    // Short timers, mid margin: many full breaths.
    load_settings(CfgDataW'($urandom_range(40)), CfgDataW'($urandom_range(400)),
                  CfgDataW'($urandom_range(30)), CfgDataW'($urandom_range(20)),
                  CfgDataW'($urandom_range(30)), CfgDataW'($urandom_range(1000, 8000)),
                  CfgDataW'($urandom_range(128, 512)));
    random_breaths(100, 40);
    wait_for_results();
    idle_on <= 1'b0;
    random_breaths(100, 40);
    idle_on <= 1'b1;
    wait_for_results();

    // Every register at zero.
    load_settings('0, '0, '0, '0, '0, '0, '0);
    random_breaths(80, 4);
    wait_for_results();

    // Every register at its top; the upper data bits must be masked off.
    load_settings('1, '1, '1, '1, '1, '1, '1);
    random_breaths(100, 70000);
    wait_for_results();

    // Full-range random settings, twice.
    repeat (2) begin
      load_settings(CfgDataW'($urandom), CfgDataW'($urandom), CfgDataW'($urandom),
                    CfgDataW'($urandom), CfgDataW'($urandom), CfgDataW'($urandom),
                    CfgDataW'($urandom));
      random_breaths(85, 70000);
      wait_for_results();
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    if (breath_sb.mismatches == 0 && breath_sb.pending() == 0) begin
      $display("tb_assist_control_breath_sequencer_core: PASS");
    end else begin
      $display("tb_assist_control_breath_sequencer_core: FAIL");
    end
    $finish;
  end

endmodule
